// ===== rtl/core/fog_parameter_crossfade_core_defines.svh =====
// assertion macros for the fog parameter crossfade core
// no dependencies; included by the files that carry concurrent checks
// the including module must have i_clk and i_rst_n
`ifndef FOG_PARAMETER_CROSSFADE_CORE_DEFINES_SVH
`define FOG_PARAMETER_CROSSFADE_CORE_DEFINES_SVH
`ifndef ASSERT_OFF
// check on every clock, masked while reset is asserted
`define FPC_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
// check on every clock, reset included
`define FPC_ASSERT_RST(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);
`else
`define FPC_ASSERT(label, prop, msg)
`define FPC_ASSERT_RST(label, prop, msg)
`endif
`endif

// ===== rtl/core/fpc_pkg.sv =====
// shared types and constants of the fog parameter crossfade core
// no dependencies; used by the interfaces, controller, datapath and top level
package fpc_pkg;

    // default widths for the top level parameters
    localparam int VALUE_BITS_DEF = 16;
    localparam int TICK_BITS_DEF  = 16;

    // fixed widths of the request and response fields
    localparam int FIELD_W = 16;
    localparam int COLOR_W = 8;

    // color scale for the 8-bit outputs
    localparam int C8_SCALE = 255;

    // reset gray level, 0.3 of full scale
    localparam int GRAY_RESET = 19661;

    // channel codes
    localparam int NUM_CH = 4;
    typedef logic [1:0] t_ch;
    localparam t_ch CH_DENSITY = 2'd0;
    localparam t_ch CH_RED     = 2'd1;
    localparam t_ch CH_GREEN   = 2'd2;
    localparam t_ch CH_BLUE    = 2'd3;

    // request payload
    typedef struct packed {
        logic               action;
        logic [FIELD_W-1:0] new_density;
        logic [FIELD_W-1:0] new_red;
        logic [FIELD_W-1:0] new_green;
        logic [FIELD_W-1:0] new_blue;
        logic [FIELD_W-1:0] fade_ticks;
    } t_in_item;

    // response payload
    typedef struct packed {
        logic [FIELD_W-1:0] density_out;
        logic [COLOR_W-1:0] red_out;
        logic [COLOR_W-1:0] green_out;
        logic [COLOR_W-1:0] blue_out;
        logic               fog_enabled;
        logic               fading;
    } t_out_item;

    // multiplier operand selection
    typedef enum logic [1:0] {
        MUL_START_TL,
        MUL_TGT_REST,
        MUL_CUR_SCALE
    } t_mul_op;

    // controller states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_UPDATE,
        ST_BL_A,
        ST_BL_B,
        ST_BL_LD,
        ST_BL_DIV,
        ST_BL_WR,
        ST_C8_MUL,
        ST_C8_WR,
        ST_OUT
    } t_state;

    // controller to datapath commands
    typedef struct packed {
        logic    latch;
        logic    update;
        t_mul_op mul_op;
        logic    acc_load;
        logic    acc_sum;
        logic    div_load;
        logic    div_step;
        logic    cur_wr;
        logic    cur_tgt;
        logic    col_wr;
        logic    out_load;
        t_ch     ch;
    } t_dp_cmd;

    // datapath to controller status
    typedef struct packed {
        logic tick_zero;
    } t_dp_sts;

endpackage

// ===== rtl/core/fpc_intf.sv =====
// request and response channel interfaces of the fog parameter crossfade core
// depends on fpc_pkg for the payload types
interface fpc_in_if import fpc_pkg::*; ();
    logic     valid;
    logic     ready;
    t_in_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface fpc_out_if import fpc_pkg::*; ();
    logic      valid;
    logic      ready;
    t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/core/fpc_ctrl.sv =====
// sequencing state machine of the fog parameter crossfade core
// depends on fpc_pkg and the assertion macro header
`include "fog_parameter_crossfade_core_defines.svh"

module fpc_ctrl import fpc_pkg::*; #(
    parameter int VALUE_BITS = VALUE_BITS_DEF
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    output logic    o_out_valid,
    input  logic    i_out_ready,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);

    localparam int CNT_W = $clog2(VALUE_BITS);

    t_state           r_state, n_state;
    t_ch              r_ch, n_ch;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_out_valid;
    logic             out_free;

    assign out_free = !r_out_valid || i_out_ready;

    // state, channel and step counter registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_ch    <= CH_DENSITY;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_ch    <= n_ch;
            r_cnt   <= n_cnt;
        end
    end

    // response valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        n_ch    = r_ch;
        n_cnt   = r_cnt;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) n_state = ST_UPDATE;
            end
            ST_UPDATE: begin
                n_state = ST_BL_A;
                n_ch    = CH_DENSITY;
            end
            ST_BL_A: begin
                if (i_sts.tick_zero) begin
                    // no fade running: blend is the target
                    if (r_ch == CH_BLUE) begin
                        n_state = ST_C8_MUL;
                        n_ch    = CH_RED;
                    end else begin
                        n_ch = r_ch + t_ch'(1);
                    end
                end else begin
                    n_state = ST_BL_B;
                end
            end
            ST_BL_B: begin
                n_state = ST_BL_LD;
            end
            ST_BL_LD: begin
                n_state = ST_BL_DIV;
                n_cnt   = CNT_W'(VALUE_BITS - 1);
            end
            ST_BL_DIV: begin
                if (r_cnt == '0) n_state = ST_BL_WR;
                else n_cnt = r_cnt - CNT_W'(1);
            end
            ST_BL_WR: begin
                if (r_ch == CH_BLUE) begin
                    n_state = ST_C8_MUL;
                    n_ch    = CH_RED;
                end else begin
                    n_state = ST_BL_A;
                    n_ch    = r_ch + t_ch'(1);
                end
            end
            ST_C8_MUL: begin
                n_state = ST_C8_WR;
            end
            ST_C8_WR: begin
                if (r_ch == CH_BLUE) begin
                    n_state = ST_OUT;
                end else begin
                    n_state = ST_C8_MUL;
                    n_ch    = r_ch + t_ch'(1);
                end
            end
            ST_OUT: begin
                if (out_free) n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // command outputs
    always_comb begin
        o_cmd        = '0;
        o_cmd.mul_op = MUL_START_TL;
        o_cmd.ch     = r_ch;
        o_in_ready   = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready  = 1'b1;
                o_cmd.latch = i_in_valid;
            end
            ST_UPDATE: begin
                o_cmd.update = 1'b1;
            end
            ST_BL_A: begin
                if (i_sts.tick_zero) begin
                    o_cmd.cur_wr  = 1'b1;
                    o_cmd.cur_tgt = 1'b1;
                end else begin
                    o_cmd.mul_op   = MUL_START_TL;
                    o_cmd.acc_load = 1'b1;
                end
            end
            ST_BL_B: begin
                o_cmd.mul_op  = MUL_TGT_REST;
                o_cmd.acc_sum = 1'b1;
            end
            ST_BL_LD: begin
                o_cmd.div_load = 1'b1;
            end
            ST_BL_DIV: begin
                o_cmd.div_step = 1'b1;
            end
            ST_BL_WR: begin
                o_cmd.cur_wr = 1'b1;
            end
            ST_C8_MUL: begin
                o_cmd.mul_op   = MUL_CUR_SCALE;
                o_cmd.acc_load = 1'b1;
            end
            ST_C8_WR: begin
                o_cmd.col_wr = 1'b1;
            end
            ST_OUT: begin
                o_cmd.out_load = out_free;
            end
            default: begin
                o_cmd.out_load = 1'b0;
            end
        endcase
    end

    assign o_out_valid = r_out_valid;

    // checks
    `FPC_ASSERT(a_accept_starts, (i_in_valid && o_in_ready) |=> (r_state == ST_UPDATE), "accepted request did not start an update")
    `FPC_ASSERT(a_update_first_ch, (r_state == ST_UPDATE) |=> (r_ch == CH_DENSITY), "blend pass did not start at density")
    `FPC_ASSERT(a_out_slot_load, (r_state == ST_OUT && !r_out_valid) |=> (r_out_valid && r_state == ST_IDLE), "free response slot was not loaded")
    `FPC_ASSERT_RST(a_reset_idle, !i_rst_n |=> (r_state == ST_IDLE && !r_out_valid), "reset did not return to idle")

endmodule

// ===== rtl/core/fpc_dp.sv =====
// datapath of the fog parameter crossfade core: state registers, shared
// multiplier and serial restoring divider; depends on fpc_pkg
module fpc_dp import fpc_pkg::*; #(
    parameter int VALUE_BITS = VALUE_BITS_DEF,
    parameter int TICK_BITS  = TICK_BITS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_dp_cmd   i_cmd,
    output t_dp_sts   o_sts,
    input  t_in_item  i_item,
    output t_out_item o_item
);

    localparam int PROD_W = VALUE_BITS + TICK_BITS;
    localparam int C8_W   = PROD_W + 1;
    localparam int DV_W   = (VALUE_BITS > TICK_BITS) ? VALUE_BITS : TICK_BITS;
    localparam int SV_W   = (VALUE_BITS > FIELD_W) ? VALUE_BITS : FIELD_W;
    localparam int ST_W   = (TICK_BITS > FIELD_W) ? TICK_BITS : FIELD_W;

    localparam logic [VALUE_BITS-1:0] VAL_MAX  = {VALUE_BITS{1'b1}};
    localparam logic [TICK_BITS-1:0]  TICK_MAX = {TICK_BITS{1'b1}};
    localparam logic [VALUE_BITS-1:0] GRAY_V   = VALUE_BITS'(GRAY_RESET);
    localparam logic [PROD_W-1:0]     HALF_MAX = PROD_W'(VAL_MAX >> 1);

    // clamp a request field to the value range
    function automatic logic [VALUE_BITS-1:0] sat_val(input logic [FIELD_W-1:0] x);
        logic [SV_W-1:0] xe;
        xe = SV_W'(x);
        if (xe > SV_W'(VAL_MAX)) sat_val = VAL_MAX;
        else sat_val = VALUE_BITS'(xe);
    endfunction

    // clamp a fade length to the tick range
    function automatic logic [TICK_BITS-1:0] sat_tick(input logic [FIELD_W-1:0] x);
        logic [ST_W-1:0] xe;
        xe = ST_W'(x);
        if (xe > ST_W'(TICK_MAX)) sat_tick = TICK_MAX;
        else sat_tick = TICK_BITS'(xe);
    endfunction

    // latched request
    logic                  r_act;
    logic [VALUE_BITS-1:0] r_new [NUM_CH];
    logic [TICK_BITS-1:0]  r_ft;

    // fade state
    logic [VALUE_BITS-1:0] r_tgt   [NUM_CH];
    logic [VALUE_BITS-1:0] r_start [NUM_CH];
    logic [VALUE_BITS-1:0] r_cur   [NUM_CH];
    logic [TICK_BITS-1:0]  r_len;
    logic [TICK_BITS-1:0]  r_tl;

    // arithmetic
    logic [PROD_W-1:0]     r_acc;
    logic [PROD_W-1:0]     r_num;
    logic [DV_W-1:0]       r_rem;
    logic [DV_W-1:0]       r_dvs;
    logic [VALUE_BITS-1:0] r_quo;
    logic [COLOR_W-1:0]    r_red, r_green, r_blue;
    t_out_item             r_out;

    logic [VALUE_BITS-1:0] sel_start, sel_tgt, sel_cur;
    logic [VALUE_BITS-1:0] mul_a;
    logic [TICK_BITS-1:0]  mul_b;
    logic [PROD_W-1:0]     mul_p;
    logic [DV_W:0]         trial;
    logic                  take;
    logic [C8_W-1:0]       c8_sum;
    logic [COLOR_W-1:0]    c8_quo;

    assign sel_start = r_start[i_cmd.ch];
    assign sel_tgt   = r_tgt[i_cmd.ch];
    assign sel_cur   = r_cur[i_cmd.ch];

    // latch request payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_act             <= i_item.action;
            r_new[CH_DENSITY] <= sat_val(i_item.new_density);
            r_new[CH_RED]     <= sat_val(i_item.new_red);
            r_new[CH_GREEN]   <= sat_val(i_item.new_green);
            r_new[CH_BLUE]    <= sat_val(i_item.new_blue);
            r_ft              <= sat_tick(i_item.fade_ticks);
        end
    end

    // fade state: tick countdown, new target load, blend write back
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_CH; k++) begin
                r_tgt[k]   <= (k == CH_DENSITY) ? '0 : GRAY_V;
                r_start[k] <= (k == CH_DENSITY) ? '0 : GRAY_V;
                r_cur[k]   <= (k == CH_DENSITY) ? '0 : GRAY_V;
            end
            r_len <= '0;
            r_tl  <= '0;
        end else if (i_cmd.update) begin
            if (!r_act) begin
                if (r_tl != '0) r_tl <= r_tl - TICK_BITS'(1);
            end else begin
                // for a nonzero fade length, the shown blend becomes the start set of a new fade
                for (int k = 0; k < NUM_CH; k++) begin
                    if (r_ft != '0) r_start[k] <= r_cur[k];
                    r_tgt[k] <= r_new[k];
                end
                r_len <= r_ft;
                r_tl  <= r_ft;
            end
        end else if (i_cmd.cur_wr) begin
            r_cur[i_cmd.ch] <= i_cmd.cur_tgt ? sel_tgt : r_quo;
        end
    end

    assign o_sts.tick_zero = (r_tl == '0);

    // shared multiplier operands
    always_comb begin
        case (i_cmd.mul_op)
            MUL_START_TL: begin
                mul_a = sel_start;
                mul_b = r_tl;
            end
            MUL_TGT_REST: begin
                mul_a = sel_tgt;
                mul_b = r_len - r_tl;
            end
            MUL_CUR_SCALE: begin
                mul_a = sel_cur;
                mul_b = TICK_BITS'(C8_SCALE);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);

    // divider step: shift in one numerator bit, subtract when it fits
    assign trial = {r_rem, r_num[PROD_W-1]};
    assign take  = (trial >= {1'b0, r_dvs});

    // divide by full scale 2^n-1: q = (y + (y >> n) + 1) >> n, exact while q < 2^n
    assign c8_sum = {1'b0, r_acc} + C8_W'(r_acc >> VALUE_BITS) + C8_W'(1);
    assign c8_quo = c8_sum[VALUE_BITS +: COLOR_W];

    // accumulator and divider
    always_ff @(posedge i_clk) begin
        if (i_cmd.acc_load) begin
            r_acc <= mul_p + ((i_cmd.mul_op == MUL_CUR_SCALE) ? HALF_MAX : '0);
        end else if (i_cmd.acc_sum) begin
            r_acc <= r_acc + mul_p + PROD_W'(r_len >> 1);
        end
        if (i_cmd.div_load) begin
            r_quo <= '0;
            r_dvs <= DV_W'(r_len);
            r_rem <= DV_W'(r_acc >> VALUE_BITS);
            r_num <= r_acc << TICK_BITS;
        end else if (i_cmd.div_step) begin
            r_rem <= take ? DV_W'(trial - {1'b0, r_dvs}) : DV_W'(trial);
            r_quo <= {r_quo[VALUE_BITS-2:0], take};
            r_num <= r_num << 1;
        end
    end

    // 8-bit color results
    always_ff @(posedge i_clk) begin
        if (i_cmd.col_wr) begin
            case (i_cmd.ch)
                CH_RED:   r_red   <= c8_quo;
                CH_GREEN: r_green <= c8_quo;
                CH_BLUE:  r_blue  <= c8_quo;
                default:  r_red   <= r_red;
            endcase
        end
    end

    // response register
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out.density_out <= FIELD_W'(r_cur[CH_DENSITY]);
            r_out.red_out     <= r_red;
            r_out.green_out   <= r_green;
            r_out.blue_out    <= r_blue;
            r_out.fog_enabled <= (r_cur[CH_DENSITY] != '0);
            r_out.fading      <= (r_tl != '0);
        end
    end

    assign o_item = r_out;

endmodule

// ===== rtl/core/fog_parameter_crossfade_core.sv =====
// fog parameter crossfade core: one response per request.
// while a fade runs, each channel's blend goes through the one-bit-per-cycle
// serial divider, otherwise the targets are written straight; one request is in
// work at a time, so a new request is taken only after the last response is
// loaded, and later while a held response keeps the output slot full.
// synchronous active-low reset loads the gray color set, zero density and no fade.
module fog_parameter_crossfade_core import fpc_pkg::*; #(
    parameter int VALUE_BITS = VALUE_BITS_DEF,
    parameter int TICK_BITS  = TICK_BITS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    fpc_in_if.sink    i_req,
    fpc_out_if.source o_rsp
);

    t_dp_cmd cmd;
    t_dp_sts sts;

    // sequencer
    fpc_ctrl #(
        .VALUE_BITS (VALUE_BITS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_req.valid),
        .o_in_ready  (i_req.ready),
        .o_out_valid (o_rsp.valid),
        .i_out_ready (o_rsp.ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    // arithmetic and state
    fpc_dp #(
        .VALUE_BITS (VALUE_BITS),
        .TICK_BITS  (TICK_BITS)
    ) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd),
        .o_sts   (sts),
        .i_item  (i_req.data),
        .o_item  (o_rsp.data)
    );

endmodule

// ===== bench/tb.sv =====
// self-checking bench for fog_parameter_crossfade_core: directed and random requests
// depends on fpc_pkg, fpc_in_if / fpc_out_if and the core rtl
module tb;
    import fpc_pkg::*;

    localparam int RUN_LIMIT   = 1_000_000;
    localparam int DRAIN_EVERY = 300;
    localparam int RAND_ITEMS  = 1050;
    localparam int HOLD_AFTER  = 150;
    localparam int HOLD_CYCLES = 500;
    localparam int TAIL_CYCLES = 150;
    localparam logic [15:0] GRAY_LVL = 16'(GRAY_RESET);
    localparam logic [15:0] FULL_LVL = 16'((1 << VALUE_BITS_DEF) - 1);

    typedef struct {
        t_in_item item;
        logic     drain;
    } t_backlog_entry;

    logic i_clk;
    logic i_rst_n;

    fpc_in_if  req_if ();
    fpc_out_if rsp_if ();

    fog_parameter_crossfade_core uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    // requests waiting to be driven, results waiting to be seen
    t_backlog_entry req_backlog[$];
    t_out_item      expected_fog[$];
    int             items_queued = 0;
    int             in_flight = 0;
    int             errors = 0;
    int             cycle_count = 0;

    // shadow fade state
    logic [15:0] tgt_lvl [NUM_CH];
    logic [15:0] src_lvl [NUM_CH];
    logic [15:0] fade_len;
    logic [15:0] fade_left;

    // driver and receiver bookkeeping
    int send_gap = 0;
    int sent_cnt = 0;
    int stall_left = 0;
    int hold_left = 0;
    int rx_seen = 0;
    int rx_cycle = 0;
    bit hold_done = 1'b0;

    // clock
    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // gap length: mostly none or short, now and then long
    function automatic int idle_span();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 65) return 0;
        if (roll < 90) return $urandom_range(1, 3);
        if (roll < 98) return $urandom_range(4, 12);
        return $urandom_range(20, 80);
    endfunction

    // linear blend of one channel, rounded to nearest
    function automatic logic [15:0] mix_level(input logic [15:0] from_lvl,
                                              input logic [15:0] to_lvl);
        logic [63:0] acc;
        logic [63:0] left;
        if (fade_left == 0 || fade_len == 0) return to_lvl;
        left = (fade_left > fade_len) ? 64'(fade_len) : 64'(fade_left);
        acc = 64'(from_lvl) * left + 64'(to_lvl) * (64'(fade_len) - left)
            + 64'(fade_len) / 2;
        acc = acc / 64'(fade_len);
        return (acc > 64'(FULL_LVL)) ? FULL_LVL : acc[15:0];
    endfunction

    // full-scale color to 8 bits, rounded to nearest
    function automatic logic [7:0] color_byte(input logic [15:0] lvl);
        logic [63:0] acc;
        acc = (64'(lvl) * C8_SCALE + 64'(FULL_LVL) / 2) / 64'(FULL_LVL);
        return acc[7:0];
    endfunction

    // advance the shadow state by one request and return the shown fog
    function automatic t_out_item predict_fog(input t_in_item req);
        t_out_item   res;
        logic [15:0] shown [NUM_CH];
        logic [15:0] new_lvl [NUM_CH];
        if (!req.action) begin
            if (fade_left != 0) fade_left = fade_left - 16'd1;
        end else begin
            new_lvl[CH_DENSITY] = req.new_density;
            new_lvl[CH_RED]     = req.new_red;
            new_lvl[CH_GREEN]   = req.new_green;
            new_lvl[CH_BLUE]    = req.new_blue;
            // nonzero fade starts from what is on screen now
            if (req.fade_ticks != 0) begin
                for (int c = 0; c < NUM_CH; c++)
                    src_lvl[c] = (fade_left != 0) ? mix_level(src_lvl[c], tgt_lvl[c])
                                                  : tgt_lvl[c];
            end
            tgt_lvl   = new_lvl;
            fade_len  = req.fade_ticks;
            fade_left = req.fade_ticks;
        end
        for (int c = 0; c < NUM_CH; c++) shown[c] = mix_level(src_lvl[c], tgt_lvl[c]);
        res.density_out = shown[CH_DENSITY];
        res.red_out     = color_byte(shown[CH_RED]);
        res.green_out   = color_byte(shown[CH_GREEN]);
        res.blue_out    = color_byte(shown[CH_BLUE]);
        res.fog_enabled = (shown[CH_DENSITY] != 0);
        res.fading      = (fade_left != 0);
        return res;
    endfunction

    function automatic t_in_item set_req(input logic [15:0] dens, input logic [15:0] red,
                                         input logic [15:0] green, input logic [15:0] blue,
                                         input logic [15:0] ticks);
        t_in_item it;
        it.action      = 1'b1;
        it.new_density = dens;
        it.new_red     = red;
        it.new_green   = green;
        it.new_blue    = blue;
        it.fade_ticks  = ticks;
        return it;
    endfunction

    // tick with a payload the core must ignore
    function automatic t_in_item tick_req(input logic [15:0] fill);
        t_in_item it;
        it = set_req(fill, ~fill, fill ^ 16'h5A5A, ~fill ^ 16'h0F0F, fill);
        it.action = 1'b0;
        return it;
    endfunction

    function automatic logic [15:0] pick_level();
        int roll;
        roll = $urandom_range(0, 9);
        if (roll == 0) return 16'h0000;
        if (roll == 1) return FULL_LVL;
        return 16'($urandom);
    endfunction

    // now and then the sender waits for every result before going on
    task automatic queue_req(input t_in_item it);
        t_backlog_entry e;
        e.item  = it;
        e.drain = (items_queued % DRAIN_EVERY) == 25;
        req_backlog.push_back(e);
        items_queued++;
    endtask

    task automatic build_directed();
        queue_req(tick_req(16'h0000));                                  // idle after reset
        queue_req(tick_req(16'hFFFF));                                  // payload ignored on tick
        queue_req(set_req(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0000)); // instant max
        queue_req(set_req(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000)); // instant zero
        queue_req(set_req(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0001)); // one-tick fade
        queue_req(tick_req(16'h0000));
        queue_req(tick_req(16'h0000));                                  // tick when idle
        queue_req(set_req(16'h1234, 16'h8000, 16'h00FF, 16'hFF00, 16'h0004));
        queue_req(tick_req(16'h0000));
        // new target mid-fade freezes the blend as start
        queue_req(set_req(16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF, 16'h0003));
        repeat (4) queue_req(tick_req(16'h0000));
        queue_req(set_req(16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555, 16'hFFFF)); // longest fade
        queue_req(tick_req(16'h0000));
        queue_req(tick_req(16'h0000));
        // zero fade mid-fade keeps the start set
        queue_req(set_req(16'h0001, 16'h0001, 16'hFFFE, 16'h8080, 16'h0000));
        queue_req(set_req(16'h7F7F, 16'h0080, 16'hFF7F, 16'h0001, 16'h0002));
        repeat (3) queue_req(tick_req(16'h0000));
    endtask

    // mostly fades with ticks, some cut short, some instant loads and bare ticks
    task automatic build_random();
        int roll;
        int len;
        int ticks;
        while (items_queued < RAND_ITEMS + 22) begin
            roll = $urandom_range(0, 99);
            if (roll < 75) begin
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 65535)
                                                  : $urandom_range(1, 8);
                queue_req(set_req(pick_level(), pick_level(), pick_level(), pick_level(),
                                  16'(len)));
                ticks = $urandom_range(0, ((len < 10) ? len : 10) + 2);
                repeat (ticks) queue_req(tick_req(16'($urandom)));
            end else if (roll < 88) begin
                queue_req(set_req(pick_level(), pick_level(), pick_level(), pick_level(),
                                  16'h0000));
            end else begin
                repeat ($urandom_range(1, 4)) queue_req(tick_req(16'($urandom)));
            end
        end
    endtask

    task automatic check_field(input string field, input logic [15:0] want,
                               input logic [15:0] got);
        if (got !== want) begin
            errors++;
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, field, want, got);
        end
    endtask

    // request driver
    always @(posedge i_clk) begin
        logic           next_valid;
        t_in_item       next_data;
        logic           took;
        t_backlog_entry e;
        if (!i_rst_n) begin
            req_if.valid <= 1'b0;
            req_if.data  <= '0;
            send_gap = 0;
        end else begin
            took       = req_if.valid && req_if.ready;
            next_valid = req_if.valid && !took;
            next_data  = req_if.data;
            if (took) begin
                sent_cnt++;
                send_gap = (((sent_cnt >> 6) & 3) == 1) ? 0 : idle_span();
            end
            if (!next_valid) begin
                if (send_gap > 0) begin
                    send_gap--;
                end else if (req_backlog.size() > 0 &&
                             (!req_backlog[0].drain || (!took && in_flight == 0))) begin
                    e          = req_backlog.pop_front();
                    next_data  = e.item;
                    next_valid = 1'b1;
                end
            end
            req_if.valid <= next_valid;
            req_if.data  <= next_data;
        end
    end

    // response receiver with random stalls and one long hold
    always @(posedge i_clk) begin
        logic rdy;
        if (!i_rst_n) begin
            rsp_if.ready <= 1'b0;
        end else begin
            rx_cycle++;
            if (rsp_if.valid && rsp_if.ready) rx_seen++;
            if (!hold_done && rx_seen >= HOLD_AFTER) begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                rdy = 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                rdy = 1'b0;
            end else if (((rx_cycle >> 9) & 3) == 0) begin
                rdy = 1'b1;
            end else begin
                stall_left = idle_span();
                rdy = (stall_left == 0);
                if (!rdy) stall_left--;
            end
            rsp_if.ready <= rdy;
        end
    end

    // monitor: check results first, then predict the request taken at this edge
    always @(posedge i_clk) begin
        t_out_item want;
        int        delta;
        if (!i_rst_n) begin
            for (int c = 0; c < NUM_CH; c++) begin
                tgt_lvl[c] = (c == CH_DENSITY) ? 16'h0000 : GRAY_LVL;
                src_lvl[c] = (c == CH_DENSITY) ? 16'h0000 : GRAY_LVL;
            end
            fade_len  = 16'h0000;
            fade_left = 16'h0000;
            in_flight <= 0;
        end else begin
            delta = 0;
            if (rsp_if.valid && rsp_if.ready) begin
                delta--;
                if (expected_fog.size() == 0) begin
                    errors++;
                    $display("%0t: response with no request pending, got %0h",
                             $time, rsp_if.data);
                end else begin
                    want = expected_fog.pop_front();
                    check_field("density_out", want.density_out, rsp_if.data.density_out);
                    check_field("red_out", 16'(want.red_out), 16'(rsp_if.data.red_out));
                    check_field("green_out", 16'(want.green_out),
                                16'(rsp_if.data.green_out));
                    check_field("blue_out", 16'(want.blue_out), 16'(rsp_if.data.blue_out));
                    check_field("fog_enabled", 16'(want.fog_enabled),
                                16'(rsp_if.data.fog_enabled));
                    check_field("fading", 16'(want.fading), 16'(rsp_if.data.fading));
                end
            end
            if (req_if.valid && req_if.ready) begin
                delta++;
                expected_fog.push_back(predict_fog(req_if.data));
            end
            in_flight <= in_flight + delta;
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > RUN_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // stimulus and end of run
    initial begin
        i_rst_n      = 1'b0;
        req_if.valid = 1'b0;
        req_if.data  = '0;
        rsp_if.ready = 1'b0;
        build_directed();
        build_random();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        do @(negedge i_clk);
        while (req_backlog.size() != 0 || req_if.valid || in_flight != 0);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (errors == 0 && expected_fog.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

// ===== fog_parameter_crossfade_core.f =====
+incdir+rtl/core
rtl/core/fpc_pkg.sv
rtl/core/fpc_intf.sv
rtl/core/fpc_ctrl.sv
rtl/core/fpc_dp.sv
rtl/core/fog_parameter_crossfade_core.sv
bench/tb.sv
